### hdl/fbso_pkg.sv
`default_nettype none

package fbso_pkg;

  // APB register map, one 32-bit word per register
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_FB_ORIGIN   = 3'd0,
    REG_FB_WIDTH    = 3'd1,
    REG_FB_HEIGHT   = 3'd2,
    REG_PIXEL_32BIT = 3'd3,
    REG_MEMORY_SIZE = 3'd4
  } cfg_reg_e;

  localparam int unsigned OriginW = 24;
  localparam int unsigned DimW    = 11;
  localparam int unsigned MemW    = 25;
  localparam int unsigned AddrW   = 26;
  localparam int unsigned WordW   = 32;

  localparam logic [OriginW-1:0] FbOriginRst   = 24'd0;
  localparam logic [DimW-1:0]    FbWidthRst    = 11'd320;
  localparam logic [DimW-1:0]    FbHeightRst   = 11'd240;
  localparam logic               Pixel32Rst    = 1'b0;
  localparam logic [MemW-1:0]    MemorySizeRst = 25'd8388608;

  // pixel that has its address and flags settled, waiting for color expansion
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [AddrW-1:0] addr;
    logic             mode32;
    logic             oor;
    logic             last;
  } fbso_pix_t;

  // 5-bit channel to 8 bits by replicating the top bits
  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

endpackage

`default_nettype wire

### hdl/framebuffer_scanout_rgba_core.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_ready_o   | pixel_word_i
// result   | out       | out_valid_o / out_ready_i | red/green/blue/alpha, pixel_address,
//          |           |                           | out_of_range, frame_last
// config   | in        | psel/penable/pwrite       | paddr, pwdata, prdata
//
// One pixel per cycle sustained while out_ready_i holds; a pixel passes stage one, then stage two.
// Stage one holds the word with its address and flags, stage two the expanded bytes.
// Counters and the running address advance at the input transfer.
// Reset clears counters, address and valid flags and loads the register defaults.
// A stalled result holds stage two; stage one still takes a pixel while it is empty.
`default_nettype none

module framebuffer_scanout_rgba_core
  import fbso_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  // pixel input
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [WordW-1:0]    pixel_word_i,
  // result
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [7:0]          red_o,
  output logic      [7:0]          green_o,
  output logic      [7:0]          blue_o,
  output logic      [7:0]          alpha_o,
  output logic      [AddrW-1:0]    pixel_address_o,
  output logic                     out_of_range_o,
  output logic                     frame_last_o
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WCmpW = ($clog2(MAX_WIDTH + 1) > DimW) ?
                                  $clog2(MAX_WIDTH + 1) : DimW;
  localparam int unsigned HCmpW = ($clog2(MAX_HEIGHT + 1) > DimW) ?
                                  $clog2(MAX_HEIGHT + 1) : DimW;
  localparam int unsigned OrgKeep = (ADDRESS_BITS < OriginW) ? ADDRESS_BITS : OriginW;
  localparam logic [OriginW-1:0] OrgMask = OriginW'((64'd1 << OrgKeep) - 64'd1);

  // ---------------- configuration registers ----------------
  logic [OriginW-1:0] fb_origin_q;
  logic [DimW-1:0]    fb_width_q, fb_height_q;
  logic               pixel_32bit_q;
  logic [MemW-1:0]    memory_size_q;
  logic               cfg_we;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_origin_q   <= FbOriginRst;
      fb_width_q    <= FbWidthRst;
      fb_height_q   <= FbHeightRst;
      pixel_32bit_q <= Pixel32Rst;
      memory_size_q <= MemorySizeRst;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_FB_ORIGIN:   fb_origin_q   <= pwdata[OriginW-1:0];
        REG_FB_WIDTH:    fb_width_q    <= pwdata[DimW-1:0];
        REG_FB_HEIGHT:   fb_height_q   <= pwdata[DimW-1:0];
        REG_PIXEL_32BIT: pixel_32bit_q <= pwdata[0];
        REG_MEMORY_SIZE: memory_size_q <= pwdata[MemW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FB_ORIGIN:   prdata = CfgDataW'(fb_origin_q);
      REG_FB_WIDTH:    prdata = CfgDataW'(fb_width_q);
      REG_FB_HEIGHT:   prdata = CfgDataW'(fb_height_q);
      REG_PIXEL_32BIT: prdata = CfgDataW'(pixel_32bit_q);
      REG_MEMORY_SIZE: prdata = CfgDataW'(memory_size_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- raster walk ----------------
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] run_addr_q, run_addr_d;
  logic [WCmpW-1:0] w_eff, w_raw, col_inc;
  logic [HCmpW-1:0] h_eff, h_raw, row_inc;
  logic [AddrW-1:0] bpp, origin_addr;
  logic             col_wrap, row_wrap, last;
  logic             oor;
  logic             in_xfer;

  assign w_raw = WCmpW'(fb_width_q);
  assign h_raw = HCmpW'(fb_height_q);

  // clamp geometry to 1..max
  always_comb begin
    if (w_raw == '0)                      w_eff = WCmpW'(1);
    else if (w_raw > WCmpW'(MAX_WIDTH))   w_eff = WCmpW'(MAX_WIDTH);
    else                                  w_eff = w_raw;
    if (h_raw == '0)                      h_eff = HCmpW'(1);
    else if (h_raw > HCmpW'(MAX_HEIGHT))  h_eff = HCmpW'(MAX_HEIGHT);
    else                                  h_eff = h_raw;
  end

  assign col_inc     = WCmpW'(col_q) + WCmpW'(1);
  assign row_inc     = HCmpW'(row_q) + HCmpW'(1);
  assign col_wrap    = col_inc >= w_eff;
  assign row_wrap    = row_inc >= h_eff;
  assign last        = col_wrap & row_wrap;
  assign bpp         = pixel_32bit_q ? AddrW'(4) : AddrW'(2);
  assign origin_addr = AddrW'(fb_origin_q & OrgMask);
  assign oor         = ({1'b0, run_addr_q} + {1'b0, bpp}) > (AddrW + 1)'(memory_size_q);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    run_addr_d = run_addr_q;
    if (in_xfer) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[ColW-1:0];
      end
      run_addr_d = last ? origin_addr : run_addr_q + bpp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      run_addr_q <= AddrW'(FbOriginRst & OrgMask);
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      run_addr_q <= run_addr_d;
    end
  end

  // ---------------- pipeline ----------------
  fbso_pix_t  s1_q;
  logic       s1_valid_q, s2_valid_q;
  logic       s2_load;
  logic [7:0] red_d, green_d, blue_d, alpha_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [AddrW-1:0] addr_q;
  logic       oor_q, last_q;

  assign s2_load    = s1_valid_q & (~s2_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s2_load;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (~s2_valid_q | out_ready_i) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.word   <= pixel_word_i;
      s1_q.addr   <= run_addr_q;
      s1_q.mode32 <= pixel_32bit_q;
      s1_q.oor    <= oor;
      s1_q.last   <= last;
    end
  end

  // expand the pixel to bytes
  always_comb begin
    if (s1_q.oor) begin
      red_d   = 8'h00;
      green_d = 8'h00;
      blue_d  = 8'h00;
      alpha_d = 8'hFF;
    end else if (s1_q.mode32) begin
      red_d   = s1_q.word[31:24];
      green_d = s1_q.word[23:16];
      blue_d  = s1_q.word[15:8];
      alpha_d = s1_q.word[7:0];
    end else begin
      red_d   = widen5(s1_q.word[15:11]);
      green_d = widen5(s1_q.word[10:6]);
      blue_d  = widen5(s1_q.word[5:1]);
      alpha_d = s1_q.word[0] ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      addr_q  <= s1_q.addr;
      oor_q   <= s1_q.oor;
      last_q  <= s1_q.last;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;
  assign alpha_o         = alpha_q;
  assign pixel_address_o = addr_q;
  assign out_of_range_o  = oor_q;
  assign frame_last_o    = last_q;

endmodule

`default_nettype wire

### hdl/fbso_checker.sv
`default_nettype none

module fbso_checker
  import fbso_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             pready,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [7:0]       red_o,
  input wire logic [7:0]       green_o,
  input wire logic [7:0]       blue_o,
  input wire logic [7:0]       alpha_o,
  input wire logic [AddrW-1:0] pixel_address_o,
  input wire logic             out_of_range_o,
  input wire logic             frame_last_o
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o)
      && $stable(alpha_o) && $stable(pixel_address_o) && $stable(out_of_range_o)
      && $stable(frame_last_o))
    else $error("result payload changed while stalled");

  // an out-of-range pixel is opaque black
  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      red_o == 8'h00 && green_o == 8'h00 && blue_o == 8'h00 && alpha_o == 8'hFF)
    else $error("out-of-range pixel not opaque black");

  // input only stalls behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with result side free");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind framebuffer_scanout_rgba_core fbso_checker u_fbso_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .red_o           (red_o),
  .green_o         (green_o),
  .blue_o          (blue_o),
  .alpha_o         (alpha_o),
  .pixel_address_o (pixel_address_o),
  .out_of_range_o  (out_of_range_o),
  .frame_last_o    (frame_last_o)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fbso_pkg::*;

  localparam int          MaxDim         = 1024;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned HoldOffCycles  = 200;
  localparam int unsigned EndSettleCycles = 8;
  localparam int unsigned ShownMismatches = 10;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [AddrW-1:0] addr;
    logic             oor;
    logic             last;
  } scan_pixel_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [CfgAddrW-1:0] paddr        = '0;
  logic [CfgDataW-1:0] pwdata       = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [WordW-1:0]    pixel_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic [7:0]          alpha_o;
  logic [AddrW-1:0]    pixel_address_o;
  logic                out_of_range_o;
  logic                frame_last_o;

  framebuffer_scanout_rgba_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_word_i    (pixel_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .pixel_address_o (pixel_address_o),
    .out_of_range_o  (out_of_range_o),
    .frame_last_o    (frame_last_o)
  );

  // scanout state mirrored from the register writes and the accepted pixels
  logic [OriginW-1:0] cfg_origin   = FbOriginRst;
  logic [DimW-1:0]    cfg_width    = FbWidthRst;
  logic [DimW-1:0]    cfg_height   = FbHeightRst;
  logic               cfg_mode32   = Pixel32Rst;
  logic [MemW-1:0]    cfg_mem_size = MemorySizeRst;
  int                 col_cnt      = 0;
  int                 row_cnt      = 0;
  logic [AddrW-1:0]   scan_addr    = '0;

  scan_pixel_t expected_pixels[$];

  int unsigned sender_idle_pct   = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned hold_off_requests = 0;
  int unsigned pixels_sent       = 0;
  int unsigned pixels_checked    = 0;
  int unsigned frames_seen       = 0;
  int unsigned oor_seen          = 0;
  int unsigned mismatches        = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(input logic [DimW-1:0] dim);
    if (dim == 0) return 1;
    if (dim > MaxDim) return MaxDim;
    return int'(dim);
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] chan);
    return (8'(chan) << 3) | (8'(chan) >> 2);
  endfunction

  // Compute the result of one transferred pixel word and advance the raster.
  task automatic predict_scanout(input logic [WordW-1:0] word);
    scan_pixel_t   px;
    logic [2:0]    bpp;
    logic [AddrW:0] fetch_end;
    int            w;
    int            h;
    bpp       = cfg_mode32 ? 3'd4 : 3'd2;
    w         = clamp_dim(cfg_width);
    h         = clamp_dim(cfg_height);
    fetch_end = {1'b0, scan_addr} + bpp;
    px.addr   = scan_addr;
    px.oor    = fetch_end > {2'b00, cfg_mem_size};
    px.last   = 1'b0;
    if (px.oor) begin
      px.red   = 8'h00;
      px.green = 8'h00;
      px.blue  = 8'h00;
      px.alpha = 8'hFF;
    end else if (cfg_mode32) begin
      px.red   = word[31:24];
      px.green = word[23:16];
      px.blue  = word[15:8];
      px.alpha = word[7:0];
    end else begin
      px.red   = expand5(word[15:11]);
      px.green = expand5(word[10:6]);
      px.blue  = expand5(word[5:1]);
      px.alpha = word[0] ? 8'hFF : 8'h00;
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        row_cnt = 0;
        px.last = 1'b1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    // reload the origin only when a frame ends
    if (px.last) scan_addr = AddrW'(cfg_origin);
    else scan_addr = fetch_end[AddrW-1:0];
    expected_pixels.push_back(px);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FB_ORIGIN:   cfg_origin   = value[OriginW-1:0];
      REG_FB_WIDTH:    cfg_width    = value[DimW-1:0];
      REG_FB_HEIGHT:   cfg_height   = value[DimW-1:0];
      REG_PIXEL_32BIT: cfg_mode32   = value[0];
      REG_MEMORY_SIZE: cfg_mem_size = value[MemW-1:0];
      default: ;
    endcase
    // idle the bus between writes
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [WordW-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    predict_scanout(word);
  endtask

  // Stop offering pixels and wait until every result has been transferred.
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic test_rgba5551_defaults();
    sender_idle_pct = 20;
    recv_idle_pct   = 20;
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_F800);
    send_pixel(32'hAAAA_07C0);
    send_pixel(32'h5555_003E);
    send_pixel(32'h0000_0001);
    drain_pixels();
  endtask

  // switch to 32-bit pixels in the middle of the reset frame
  task automatic test_rgba8888();
    write_reg(REG_PIXEL_32BIT, 32'd1);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'h1234_5678);
    drain_pixels();
  endtask

  task automatic test_frame_geometry();
    // a new origin takes effect only after the current frame ends
    write_reg(REG_FB_ORIGIN, 32'h0000_0100);
    send_pixel($urandom);
    drain_pixels();
    // zero geometry acts as a one-pixel frame; counters beyond it wrap
    write_reg(REG_FB_WIDTH, 32'd0);
    write_reg(REG_FB_HEIGHT, 32'd0);
    repeat (2) send_pixel($urandom);
    drain_pixels();
    write_reg(REG_FB_WIDTH, 32'd2047);
    write_reg(REG_FB_HEIGHT, 32'd2047);
    repeat (3) send_pixel($urandom);
    drain_pixels();
    write_reg(REG_FB_WIDTH, 32'd2);
    write_reg(REG_FB_HEIGHT, 32'd2);
    repeat (3) send_pixel($urandom);
    drain_pixels();
  endtask

  task automatic test_memory_limit();
    // last in-range pixel ends exactly at the memory size
    write_reg(REG_MEMORY_SIZE, 32'(scan_addr) + 32'd8);
    repeat (4) send_pixel($urandom);
    drain_pixels();
    write_reg(REG_MEMORY_SIZE, 32'd0);
    send_pixel($urandom);
    drain_pixels();
    write_reg(REG_PIXEL_32BIT, 32'd0);
    write_reg(REG_MEMORY_SIZE, 32'(scan_addr) + 32'd3);
    repeat (2) send_pixel(32'hFFFF_FFFF);
    drain_pixels();
    write_reg(REG_MEMORY_SIZE, 32'h01FF_FFFF);
  endtask

  // Hold the result side off long enough to fill the pipeline and stall input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_off_requests <= hold_off_requests + 1;
    repeat (30) send_pixel($urandom);
    drain_pixels();
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(15))
      0:       return '0;
      1:       return DimW'(MaxDim);
      2:       return DimW'($urandom_range(MaxDim + 1, 2047));
      3:       return '1;
      default: return DimW'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic pick_setup();
    logic [MemW-1:0] mem;
    if ($urandom_range(1)) write_reg(REG_PIXEL_32BIT, 32'($urandom_range(1)));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       write_reg(REG_FB_ORIGIN, 32'd0);
        1:       write_reg(REG_FB_ORIGIN, 32'h00FF_FFFF);
        default: write_reg(REG_FB_ORIGIN, $urandom & 32'h00FF_FFFF);
      endcase
    end
    if ($urandom_range(1)) write_reg(REG_FB_WIDTH, 32'(pick_dim()));
    if ($urandom_range(1)) write_reg(REG_FB_HEIGHT, 32'(pick_dim()));
    case ($urandom_range(7))
      0:       mem = '0;
      1:       mem = '1;
      2:       mem = MemW'(24'hFF_FFFF) + 1'b1;
      3:       mem = MemW'($urandom);
      // put the memory end up to 96 bytes ahead so the boundary can be crossed
      default: mem = MemW'(scan_addr) + MemW'($urandom_range(0, 96));
    endcase
    write_reg(REG_MEMORY_SIZE, 32'(mem));
  endtask

  task automatic test_random_scan(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned n_items);
    int unsigned sent = 0;
    int unsigned burst;
    sender_idle_pct = send_pct;
    recv_idle_pct   = recv_pct;
    while (sent < n_items) begin
      drain_pixels();
      pick_setup();
      burst = $urandom_range(8, 48);
      repeat (burst) send_pixel($urandom);
      sent += burst;
    end
    drain_pixels();
  endtask

  // result side: random stalls, plus a counted hold-off on request
  initial begin
    int unsigned served = 0;
    int unsigned hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_requests != served) begin
        served    = hold_off_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    scan_pixel_t want;
    scan_pixel_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{red_o, green_o, blue_o, alpha_o, pixel_address_o, out_of_range_o, frame_last_o};
      pixels_checked++;
      if (got.last) frames_seen++;
      if (got.oor) oor_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMismatches)
          $display("ERROR: result with no pixel pending, addr=%h", got.addr);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.addr !== want.addr || got.oor !== want.oor ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= ShownMismatches) begin
            $display("ERROR: pixel %0d expected rgba=%h_%h_%h_%h addr=%h oor=%b last=%b",
                     pixels_checked, want.red, want.green, want.blue, want.alpha,
                     want.addr, want.oor, want.last);
            $display("       pixel %0d actual   rgba=%h_%h_%h_%h addr=%h oor=%b last=%b",
                     pixels_checked, got.red, got.green, got.blue, got.alpha,
                     got.addr, got.oor, got.last);
          end
        end
      end
    end
  end

  // end the run if no transfer happens for too long
  initial begin
    int unsigned quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
             WatchdogLimit, expected_pixels.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rgba5551_defaults();
    test_rgba8888();
    test_frame_geometry();
    test_memory_limit();
    test_backpressure();
    test_random_scan(6, 81, 480);
    test_random_scan(81, 6, 480);
    test_random_scan(0, 0, 480);
    drain_pixels();
    repeat (EndSettleCycles) @(posedge clk_i);
    mismatches += expected_pixels.size();
    $display("Scanned %0d pixels in both pixel formats over varied geometry and memory sizes,",
             pixels_sent);
    $display("checked %0d results: %0d frame ends, %0d beyond memory, %0d mismatches.",
             pixels_checked, frames_seen, oor_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hdl/fbso_pkg.sv
hdl/framebuffer_scanout_rgba_core.sv
hdl/fbso_checker.sv
tb/sv/testbench.sv
